// ===== src/pgs_pkg.sv =====
// ----------------------------------------------------------------------------
// pgs_pkg
// shared widths, constants and the front-to-back word for the polar gaussian
// sampler
// ----------------------------------------------------------------------------
package pgs_pkg;

  localparam int SAMPLE_FRACTION_BITS = 15;
  localparam int SAMPLE_W = 16;
  localparam int CFG_W = 32;
  localparam int HALF_W = 32;

  // squared radius and its top-bit index
  localparam int SUMSQ_W = 2 * SAMPLE_W;
  localparam int Q_W = 2 * SAMPLE_FRACTION_BITS;
  localparam int P_W = $clog2(Q_W);

  // log2 by repeated squaring
  localparam int MANT_W = 32;
  localparam int LOG_ROUNDS = 32;
  localparam int NL2_W = MANT_W + $clog2(Q_W + 1);
  localparam int LN_SHIFT = 62;
  localparam int LN_C_W = 63;
  localparam logic [LN_C_W-1:0] TWO_LN2_Q62 = 63'h58B90BFBE8E7BCD6;
  localparam int LN_PROD_W = NL2_W + LN_C_W;
  localparam int W_W = LN_PROD_W - LN_SHIFT;

  // divide by q, then square root
  localparam int DVD_SHIFT = 84;
  localparam int DIV_BITS = 2;
  localparam int DIV_STAGES = (W_W + DVD_SHIFT + DIV_BITS - 1) / DIV_BITS;
  localparam int DVD_W = DIV_BITS * DIV_STAGES;
  localparam int SQ_STEPS = 2;
  localparam int SQ_STAGES = (DVD_W + 2 * SQ_STEPS - 1) / (2 * SQ_STEPS);
  localparam int RAD_W = 2 * SQ_STEPS * SQ_STAGES;
  localparam int ROOT_W = SQ_STEPS * SQ_STAGES;
  localparam int SQ_REM_W = ROOT_W + 2;
  localparam int SQ_CUR_W = ROOT_W + 4;

  // final scaling
  localparam int PROD_W = CFG_W + SAMPLE_W;
  localparam int MUL_W = PROD_W + ROOT_W;
  localparam int SCALE_SHIFT = 58;
  localparam int Y_W = MUL_W - SCALE_SHIFT;
  localparam int TOT_W = Y_W + 2;

  // stages from the queue output to the result register
  localparam int BACK_LAT = LOG_ROUNDS + DIV_STAGES + SQ_STAGES + 9;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // register map
  localparam int CFG_ADDR_W = 3;
  localparam int REG_SEL_BIT = 2;
  localparam logic [0:0] REG_MEAN_OFFSET = 1'b0;
  localparam logic [0:0] REG_SPREAD_SCALE = 1'b1;
  localparam logic signed [CFG_W-1:0] MEAN_RESET = 32'sd0;
  localparam logic signed [CFG_W-1:0] SPREAD_RESET = 32'sd65536;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] u;
    logic [Q_W-1:0]             q;
    logic [MANT_W-1:0]          mant;
    logic [P_W-1:0]             top;
  } item_t;

endpackage

// ===== src/pgs_front.sv =====
// ----------------------------------------------------------------------------
// pgs_front
// takes a sample pair, forms the squared radius, drops pairs at the origin or
// on or outside the unit circle and normalizes the rest for the log stage
// ----------------------------------------------------------------------------
module pgs_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  accept,
  input  logic signed [pgs_pkg::SAMPLE_W-1:0]   u_sample,
  input  logic signed [pgs_pkg::SAMPLE_W-1:0]   v_sample,
  output logic                                  push,
  output pgs_pkg::item_t                        item
);
  import pgs_pkg::*;

  logic                       a_v_r;
  logic signed [SAMPLE_W-1:0] a_u_r;
  logic [SUMSQ_W-1:0]         a_q_r;
  logic [SUMSQ_W-1:0]         a_q_nxt;
  logic signed [SUMSQ_W-1:0]  uu;
  logic signed [SUMSQ_W-1:0]  vv;
  logic [Q_W-1:0]             qn;
  logic [P_W-1:0]             top;
  logic [P_W:0]               sh;

  always_comb begin
    uu = SUMSQ_W'(u_sample) * SUMSQ_W'(u_sample);
    vv = SUMSQ_W'(v_sample) * SUMSQ_W'(v_sample);
    a_q_nxt = $unsigned(uu) + $unsigned(vv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_u_r <= u_sample;
      a_q_r <= a_q_nxt;
    end
  end

  // leading one of the squared radius
  always_comb begin
    qn = a_q_r[Q_W-1:0];
    top = '0;
    for (int i = 0; i < Q_W; i++) begin
      if (qn[i]) begin
        top = P_W'(i);
      end
    end
    sh = (P_W+1)'(MANT_W - 1) - (P_W+1)'(top);
  end

  assign push = a_v_r && (a_q_r != '0) && (a_q_r[SUMSQ_W-1:Q_W] == '0);

  always_comb begin
    item.u = a_u_r;
    item.q = qn;
    item.mant = MANT_W'(qn) << sh;
    item.top = top;
  end

endmodule

// ===== src/pgs_queue.sv =====
// ----------------------------------------------------------------------------
// pgs_queue
// short fifo between the classifier and the arithmetic pipeline
// ----------------------------------------------------------------------------
module pgs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pgs_pkg::item_t push_item,
  output logic           full,
  output logic           pop_valid,
  output pgs_pkg::item_t pop_item
);
  import pgs_pkg::*;

  item_t             mem_r [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              pop;

  assign full = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop = pop_valid;
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // the back end drains a word every cycle, so one slot is enough
  a_never_two: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(1))
    else $error("queue holds more than one word");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count missed a push");

endmodule

// ===== src/pgs_back.sv =====
// ----------------------------------------------------------------------------
// pgs_back
// arithmetic pipeline: log2 by squaring, scale to -2 ln q, divide by q,
// square root, multiply by scale times u, add mean and saturate
// ----------------------------------------------------------------------------
module pgs_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  pgs_pkg::item_t                     in_item,
  input  logic signed [pgs_pkg::CFG_W-1:0]   mean_offset,
  input  logic signed [pgs_pkg::CFG_W-1:0]   spread_scale,
  output logic                               out_valid,
  output logic signed [pgs_pkg::CFG_W-1:0]   out_value
);
  import pgs_pkg::*;

  // log section
  logic                       lg_v_r [0:LOG_ROUNDS];
  logic [MANT_W-1:0]          lg_m_r [0:LOG_ROUNDS];
  logic [LOG_ROUNDS-1:0]      lg_f_r [0:LOG_ROUNDS];
  logic [P_W-1:0]             lg_p_r [0:LOG_ROUNDS];
  logic [Q_W-1:0]             lg_q_r [0:LOG_ROUNDS];
  logic signed [SAMPLE_W-1:0] lg_u_r [0:LOG_ROUNDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_v_r[0] <= 1'b0;
    end else begin
      lg_v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    lg_m_r[0] <= in_item.mant;
    lg_f_r[0] <= '0;
    lg_p_r[0] <= in_item.top;
    lg_q_r[0] <= in_item.q;
    lg_u_r[0] <= in_item.u;
  end

  for (genvar k = 0; k < LOG_ROUNDS; k++) begin : g_lg
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     tr;
    logic [MANT_W-1:0]   m_nxt;
    logic                bit_nxt;

    always_comb begin
      sq = lg_m_r[k] * lg_m_r[k];
      tr = sq[2*MANT_W-1:MANT_W-1];
      bit_nxt = tr[MANT_W];
      m_nxt = bit_nxt ? tr[MANT_W:1] : tr[MANT_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        lg_v_r[k+1] <= 1'b0;
      end else begin
        lg_v_r[k+1] <= lg_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      lg_m_r[k+1] <= m_nxt;
      lg_f_r[k+1] <= {lg_f_r[k][LOG_ROUNDS-2:0], bit_nxt};
      lg_p_r[k+1] <= lg_p_r[k];
      lg_q_r[k+1] <= lg_q_r[k];
      lg_u_r[k+1] <= lg_u_r[k];
    end
  end

  // -log2 q, then times 2 ln 2
  logic                       nl_v_r;
  logic [NL2_W-1:0]           nl_r;
  logic [NL2_W-1:0]           nl_nxt;
  logic [Q_W-1:0]             nl_q_r;
  logic signed [SAMPLE_W-1:0] nl_u_r;

  assign nl_nxt = ((NL2_W'(Q_W) - NL2_W'(lg_p_r[LOG_ROUNDS])) << MANT_W)
                - NL2_W'(lg_f_r[LOG_ROUNDS]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nl_v_r <= 1'b0;
    end else begin
      nl_v_r <= lg_v_r[LOG_ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    nl_r <= nl_nxt;
    nl_q_r <= lg_q_r[LOG_ROUNDS];
    nl_u_r <= lg_u_r[LOG_ROUNDS];
  end

  logic                          pp_v_r;
  logic [2*HALF_W-1:0]           pp00_r;
  logic [LN_C_W-1:0]             pp01_r;
  logic [NL2_W-1:0]              pp10_r;
  logic [LN_C_W+NL2_W-2*HALF_W-1:0] pp11_r;
  logic [Q_W-1:0]                pp_q_r;
  logic signed [SAMPLE_W-1:0]    pp_u_r;
  logic [LN_PROD_W-1:0]          ln_prod;
  logic [W_W-1:0]                w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_v_r <= 1'b0;
    end else begin
      pp_v_r <= nl_v_r;
    end
  end

  always_ff @(posedge clk) begin
    pp00_r <= nl_r[HALF_W-1:0] * TWO_LN2_Q62[HALF_W-1:0];
    pp01_r <= nl_r[HALF_W-1:0] * TWO_LN2_Q62[LN_C_W-1:HALF_W];
    pp10_r <= nl_r[NL2_W-1:HALF_W] * TWO_LN2_Q62[HALF_W-1:0];
    pp11_r <= nl_r[NL2_W-1:HALF_W] * TWO_LN2_Q62[LN_C_W-1:HALF_W];
    pp_q_r <= nl_q_r;
    pp_u_r <= nl_u_r;
  end

  always_comb begin
    ln_prod = LN_PROD_W'(pp00_r)
            + (LN_PROD_W'(pp01_r) << HALF_W)
            + (LN_PROD_W'(pp10_r) << HALF_W)
            + (LN_PROD_W'(pp11_r) << (2 * HALF_W));
    w = ln_prod[LN_PROD_W-1:LN_SHIFT];
  end

  // restoring divider, quotient bits shift in behind the dividend
  logic                       dv_v_r   [0:DIV_STAGES];
  logic [Q_W-1:0]             dv_rem_r [0:DIV_STAGES];
  logic [DVD_W-1:0]           dv_dvd_r [0:DIV_STAGES];
  logic [Q_W-1:0]             dv_d_r   [0:DIV_STAGES];
  logic signed [SAMPLE_W-1:0] dv_u_r   [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else begin
      dv_v_r[0] <= pp_v_r;
    end
  end

  always_ff @(posedge clk) begin
    dv_rem_r[0] <= '0;
    dv_dvd_r[0] <= DVD_W'(w) << DVD_SHIFT;
    dv_d_r[0] <= pp_q_r;
    dv_u_r[0] <= pp_u_r;
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_dv
    logic [Q_W-1:0]   rem_nxt;
    logic [DVD_W-1:0] dvd_nxt;

    always_comb begin : div_step
      logic [Q_W:0] cur;
      rem_nxt = dv_rem_r[k];
      dvd_nxt = dv_dvd_r[k];
      cur = '0;
      for (int j = 0; j < DIV_BITS; j++) begin
        cur = {rem_nxt, dvd_nxt[DVD_W-1]};
        if (cur >= {1'b0, dv_d_r[k]}) begin
          rem_nxt = Q_W'(cur - {1'b0, dv_d_r[k]});
          dvd_nxt = {dvd_nxt[DVD_W-2:0], 1'b1};
        end else begin
          rem_nxt = cur[Q_W-1:0];
          dvd_nxt = {dvd_nxt[DVD_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      dv_rem_r[k+1] <= rem_nxt;
      dv_dvd_r[k+1] <= dvd_nxt;
      dv_d_r[k+1] <= dv_d_r[k];
      dv_u_r[k+1] <= dv_u_r[k];
    end
  end

  // digit-by-digit square root
  logic                       sq_v_r   [0:SQ_STAGES];
  logic [RAD_W-1:0]           sq_x_r   [0:SQ_STAGES];
  logic [SQ_REM_W-1:0]        sq_rem_r [0:SQ_STAGES];
  logic [ROOT_W-1:0]          sq_res_r [0:SQ_STAGES];
  logic signed [SAMPLE_W-1:0] sq_u_r   [0:SQ_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else begin
      sq_v_r[0] <= dv_v_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    sq_x_r[0] <= RAD_W'(dv_dvd_r[DIV_STAGES]);
    sq_rem_r[0] <= '0;
    sq_res_r[0] <= '0;
    sq_u_r[0] <= dv_u_r[DIV_STAGES];
  end

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
    logic [RAD_W-1:0]    x_nxt;
    logic [SQ_REM_W-1:0] rem_nxt;
    logic [ROOT_W-1:0]   res_nxt;

    always_comb begin : root_step
      logic [SQ_CUR_W-1:0] cur;
      logic [SQ_CUR_W-1:0] trial;
      x_nxt = sq_x_r[k];
      rem_nxt = sq_rem_r[k];
      res_nxt = sq_res_r[k];
      cur = '0;
      trial = '0;
      for (int j = 0; j < SQ_STEPS; j++) begin
        cur = {rem_nxt, x_nxt[RAD_W-1 -: 2]};
        x_nxt = x_nxt << 2;
        trial = SQ_CUR_W'({res_nxt, 2'b01});
        if (cur >= trial) begin
          rem_nxt = SQ_REM_W'(cur - trial);
          res_nxt = {res_nxt[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt = SQ_REM_W'(cur);
          res_nxt = {res_nxt[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      sq_x_r[k+1] <= x_nxt;
      sq_rem_r[k+1] <= rem_nxt;
      sq_res_r[k+1] <= res_nxt;
      sq_u_r[k+1] <= sq_u_r[k];
    end
  end

  // scale * u, then its magnitude times the root
  logic                     sc_v_r;
  logic                     sc_neg_r;
  logic [PROD_W-1:0]        sc_mag_r;
  logic [ROOT_W-1:0]        sc_f_r;
  logic signed [PROD_W-1:0] s_full;

  assign s_full = PROD_W'(spread_scale) * PROD_W'(sq_u_r[SQ_STAGES]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_v_r <= 1'b0;
    end else begin
      sc_v_r <= sq_v_r[SQ_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    sc_neg_r <= s_full[PROD_W-1];
    sc_mag_r <= s_full[PROD_W-1] ? $unsigned(-s_full) : $unsigned(s_full);
    sc_f_r <= sq_res_r[SQ_STAGES];
  end

  logic                             mp_v_r;
  logic                             mp_neg_r;
  logic [2*HALF_W-1:0]              mp00_r;
  logic [ROOT_W-1:0]                mp01_r;
  logic [PROD_W-1:0]                mp10_r;
  logic [PROD_W+ROOT_W-2*HALF_W-1:0] mp11_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mp_v_r <= 1'b0;
    end else begin
      mp_v_r <= sc_v_r;
    end
  end

  always_ff @(posedge clk) begin
    mp_neg_r <= sc_neg_r;
    mp00_r <= sc_mag_r[HALF_W-1:0] * sc_f_r[HALF_W-1:0];
    mp01_r <= sc_mag_r[HALF_W-1:0] * sc_f_r[ROOT_W-1:HALF_W];
    mp10_r <= sc_mag_r[PROD_W-1:HALF_W] * sc_f_r[HALF_W-1:0];
    mp11_r <= sc_mag_r[PROD_W-1:HALF_W] * sc_f_r[ROOT_W-1:HALF_W];
  end

  logic             y_v_r;
  logic             y_neg_r;
  logic [Y_W-1:0]   y_r;
  logic [MUL_W-1:0] mul_sum;

  assign mul_sum = MUL_W'(mp00_r)
                 + (MUL_W'(mp01_r) << HALF_W)
                 + (MUL_W'(mp10_r) << HALF_W)
                 + (MUL_W'(mp11_r) << (2 * HALF_W));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_v_r <= 1'b0;
    end else begin
      y_v_r <= mp_v_r;
    end
  end

  always_ff @(posedge clk) begin
    y_neg_r <= mp_neg_r;
    y_r <= mul_sum[MUL_W-1:SCALE_SHIFT];
  end

  // add the mean and clamp to 32 bits
  logic signed [TOT_W-1:0] y_s;
  logic signed [TOT_W-1:0] total;
  logic signed [CFG_W-1:0] value_nxt;
  logic                    out_valid_r;
  logic signed [CFG_W-1:0] out_value_r;

  always_comb begin
    y_s = $signed(TOT_W'(y_r));
    total = TOT_W'(mean_offset) + (y_neg_r ? -y_s : y_s);
    if ((&total[TOT_W-1:CFG_W-1]) || !(|total[TOT_W-1:CFG_W-1])) begin
      value_nxt = total[CFG_W-1:0];
    end else if (total[TOT_W-1]) begin
      value_nxt = {1'b1, {(CFG_W-1){1'b0}}};
    end else begin
      value_nxt = {1'b0, {(CFG_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= y_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= value_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(in_valid, BACK_LAT))
    else $error("result without a word entering the pipeline");

endmodule

// ===== src/polar_gaussian_sample_top.sv =====
// ----------------------------------------------------------------------------
// polar_gaussian_sample_top
// out_strobe rises for a taken pair once it has passed the front register, the queue and the back pipeline
// throughput: one pair per cycle, busy stays low; set by the fully pipelined
//   squaring, divider and root stages
// rejected pairs (q zero or q >= 1) give no strobe
// reset: synchronous rst_n clears the pipeline, mean_offset to 0 and
//   spread_scale to 1.0; the receiver cannot stall
// ----------------------------------------------------------------------------
module polar_gaussian_sample_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [pgs_pkg::SAMPLE_W-1:0]  in_u_sample,
  input  logic signed [pgs_pkg::SAMPLE_W-1:0]  in_v_sample,
  output logic                                 out_strobe,
  output logic signed [pgs_pkg::CFG_W-1:0]     out_normal_value,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pgs_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [pgs_pkg::CFG_W-1:0]            pwdata,
  output logic [pgs_pkg::CFG_W-1:0]            prdata,
  output logic                                 pready
);
  import pgs_pkg::*;

  logic signed [CFG_W-1:0] mean_r;
  logic signed [CFG_W-1:0] spread_r;
  logic                    accept;
  logic                    push;
  item_t                   push_item;
  logic                    full;
  logic                    pop_valid;
  item_t                   pop_item;

  // config registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= MEAN_RESET;
      spread_r <= SPREAD_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[REG_SEL_BIT])
        REG_MEAN_OFFSET:  mean_r <= pwdata;
        REG_SPREAD_SCALE: spread_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[REG_SEL_BIT])
      REG_MEAN_OFFSET:  prdata = mean_r;
      REG_SPREAD_SCALE: prdata = spread_r;
      default:          prdata = '0;
    endcase
  end

  assign busy = full;
  assign accept = start && !busy;

  pgs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .u_sample (in_u_sample),
    .v_sample (in_v_sample),
    .push     (push),
    .item     (push_item)
  );

  pgs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  pgs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (pop_valid),
    .in_item      (pop_item),
    .mean_offset  (mean_r),
    .spread_scale (spread_r),
    .out_valid    (out_strobe),
    .out_value    (out_normal_value)
  );

endmodule
